// ===== hw/rtl/checksummed_block_download_assert.svh =====
// Assertion macros used by the checksummed block download RTL.
`ifndef CHECKSUMMED_BLOCK_DOWNLOAD_ASSERT_SVH
`define CHECKSUMMED_BLOCK_DOWNLOAD_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted (active low reset)
`define CBD_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted (active low reset)
`define CBD_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

// ===== hw/rtl/cbd_pkg.sv =====
// Package: types, constants and codes of the checksummed block download receiver.
`default_nettype none
package cbd_pkg;

  // Block geometry
  localparam int BLOCK_BYTES = 512;
  localparam int POS_W       = $clog2(BLOCK_BYTES + 1);

  // Field and register widths
  localparam int COUNT_W = 25;
  localparam int TOTAL_W = 24;
  localparam int RETRY_W = 4;
  localparam int BYTE_W  = 8;
  localparam int OP_W    = 2;
  localparam int KIND_W  = 3;
  localparam int CFG_W   = TOTAL_W;
  localparam int CFG_IDX_W = 1;

  localparam logic [RETRY_W-1:0] RETRY_LIMIT_RESET = RETRY_W'(10);

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_TOTAL_BYTES = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_RETRY_LIMIT = CFG_IDX_W'(1);

  typedef enum logic [OP_W-1:0] {
    OP_START = 2'd0,
    OP_BYTE  = 2'd1,
    OP_ERROR = 2'd2
  } op_e;

  typedef enum logic [KIND_W-1:0] {
    K_STORE   = 3'd0,
    K_SENDSUM = 3'd1,
    K_ACCEPT  = 3'd2,
    K_RETRY   = 3'd3,
    K_FINISH  = 3'd4,
    K_FAIL    = 3'd5,
    K_ABORT   = 3'd6
  } kind_e;

  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_DATA  = 2'd1,
    PH_CHECK = 2'd2
  } phase_e;

  // One queued result entry; a block-end store carries the checksum beat too
  typedef struct packed {
    kind_e              kind;
    logic [COUNT_W-1:0] offset;
    logic [BYTE_W-1:0]  value;
    logic [COUNT_W-1:0] count;
    logic               two;
    logic [BYTE_W-1:0]  sum;
  } res_entry_t;

endpackage
`default_nettype wire

// ===== hw/rtl/cbd_res_q.sv =====
// Result queue: two entry slots and the beat sequencing onto the output channel.
`default_nettype none
module cbd_res_q (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        push_i,
  input  wire cbd_pkg::res_entry_t         push_data_i,
  output logic                             push_ready_o,
  output logic                             valid_o,
  input  wire logic                        ready_i,
  output logic [cbd_pkg::KIND_W-1:0]       kind_o,
  output logic [cbd_pkg::COUNT_W-1:0]      offset_o,
  output logic [cbd_pkg::BYTE_W-1:0]       value_o,
  output logic [cbd_pkg::COUNT_W-1:0]      count_o,
  output logic                             last_o
);
  import cbd_pkg::*;

  res_entry_t head_q, head_d;
  res_entry_t spare_q, spare_d;
  logic       head_vld_q, head_vld_d;
  logic       spare_vld_q, spare_vld_d;
  logic       second_q, second_d;
  logic       final_beat;
  logic       pop;

  assign push_ready_o = !spare_vld_q;
  assign final_beat   = second_q || !head_q.two;
  assign pop          = head_vld_q && ready_i && final_beat;

  // Slot movement
  always_comb begin
    head_d      = head_q;
    spare_d     = spare_q;
    head_vld_d  = head_vld_q;
    spare_vld_d = spare_vld_q;
    if (pop) begin
      if (spare_vld_q) begin
        head_d      = spare_q;
        spare_vld_d = 1'b0;
      end else begin
        head_d     = push_data_i;
        head_vld_d = push_i;
      end
    end else if (!head_vld_q) begin
      head_d     = push_data_i;
      head_vld_d = push_i;
    end else if (push_i) begin
      spare_d     = push_data_i;
      spare_vld_d = 1'b1;
    end
  end

  // Second beat of a block-end entry
  always_comb begin
    second_d = second_q;
    if (head_vld_q && ready_i) begin
      second_d = !final_beat;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_vld_q  <= 1'b0;
      spare_vld_q <= 1'b0;
      second_q    <= 1'b0;
    end else begin
      head_vld_q  <= head_vld_d;
      spare_vld_q <= spare_vld_d;
      second_q    <= second_d;
    end
  end

  always_ff @(posedge clk_i) begin
    head_q  <= head_d;
    spare_q <= spare_d;
  end

  // Output beat
  always_comb begin
    valid_o  = head_vld_q;
    count_o  = head_q.count;
    last_o   = final_beat;
    if (second_q) begin
      kind_o   = K_SENDSUM;
      offset_o = '0;
      value_o  = head_q.sum;
    end else begin
      kind_o   = head_q.kind;
      offset_o = head_q.offset;
      value_o  = head_q.value;
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/checksummed_block_download.sv =====
// Top level of the checksummed block download receiver.
// Path: each result passes through the input register and then the head slot
//   register of the result queue.
// Throughput: one item per cycle while the result queue has room; a block-end byte
//   yields two results, and the output channel moves one result per cycle when ready.
// Reset: phase idle, counters zero, total_bytes 0, retry_limit 10.
`default_nettype none
`include "checksummed_block_download_assert.svh"
module checksummed_block_download (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  // configuration write port
  input  wire logic                          cfg_we_i,
  input  wire logic [cbd_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [cbd_pkg::CFG_W-1:0]     cfg_data_i,
  // input channel
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire logic [cbd_pkg::OP_W-1:0]      op_i,
  input  wire logic [cbd_pkg::BYTE_W-1:0]    rx_byte_i,
  // output channel
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic [cbd_pkg::KIND_W-1:0]         kind_o,
  output logic [cbd_pkg::COUNT_W-1:0]        offset_o,
  output logic [cbd_pkg::BYTE_W-1:0]         value_o,
  output logic [cbd_pkg::COUNT_W-1:0]        count_o,
  output logic                               last_o
);
  import cbd_pkg::*;

  // configuration
  logic [TOTAL_W-1:0] total_q;
  logic [RETRY_W-1:0] limit_q;

  // input register
  logic              in_vld_q;
  logic [OP_W-1:0]   op_q;
  logic [BYTE_W-1:0] byte_q;

  // transfer state
  phase_e             phase_q, phase_d;
  logic [POS_W-1:0]   pos_q, pos_d;
  logic [BYTE_W-1:0]  sum_q, sum_d;
  logic [RETRY_W-1:0] retry_q, retry_d;
  logic [COUNT_W-1:0] acc_q, acc_d;

  // datapath terms
  logic [BYTE_W-1:0]  sum_add;
  logic [POS_W-1:0]   pos_inc;
  logic               blk_end;
  logic [COUNT_W-1:0] acc_add;
  logic [COUNT_W-1:0] store_off;
  logic               sum_ok;
  logic               done;
  logic               retry_out;

  logic       push_ready;
  logic       proceed;
  logic       push;
  res_entry_t ent;

  assign proceed    = in_vld_q && push_ready;
  assign in_ready_o = !in_vld_q || push_ready;

  assign sum_add   = sum_q + byte_q;
  assign pos_inc   = pos_q + POS_W'(1);
  assign blk_end   = pos_inc >= POS_W'(BLOCK_BYTES);
  assign acc_add   = acc_q + COUNT_W'(BLOCK_BYTES);
  assign store_off = acc_q + {{(COUNT_W-POS_W){1'b0}}, pos_q};
  assign sum_ok    = byte_q == sum_q;
  assign done      = acc_add >= {{(COUNT_W-TOTAL_W){1'b0}}, total_q};
  assign retry_out = retry_q >= limit_q;

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q <= '0;
      limit_q <= RETRY_LIMIT_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_TOTAL_BYTES: total_q <= cfg_data_i;
        CFG_RETRY_LIMIT: limit_q <= cfg_data_i[RETRY_W-1:0];
        default: ;
      endcase
    end
  end

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_ready_o) begin
      in_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      op_q   <= op_i;
      byte_q <= rx_byte_i;
    end
  end

  // Next phase
  always_comb begin
    phase_d = phase_q;
    unique case (op_e'(op_q))
      OP_START: phase_d = (total_q == '0) ? PH_IDLE : PH_DATA;
      OP_ERROR: phase_d = PH_IDLE;
      OP_BYTE: begin
        unique case (phase_q)
          PH_DATA:  phase_d = blk_end ? PH_CHECK : PH_DATA;
          PH_CHECK: phase_d = (sum_ok ? done : retry_out) ? PH_IDLE : PH_DATA;
          default:  phase_d = phase_q;
        endcase
      end
      default: phase_d = phase_q;
    endcase
  end

  // Counters and running sum
  always_comb begin
    pos_d   = pos_q;
    sum_d   = sum_q;
    retry_d = retry_q;
    acc_d   = acc_q;
    case (op_e'(op_q))
      OP_START: begin
        pos_d   = '0;
        sum_d   = '0;
        retry_d = '0;
        acc_d   = '0;
      end
      OP_BYTE: begin
        if (phase_q == PH_DATA) begin
          pos_d = pos_inc;
          sum_d = sum_add;
        end else if (phase_q == PH_CHECK) begin
          pos_d = '0;
          sum_d = '0;
          if (sum_ok) begin
            acc_d   = acc_add;
            retry_d = '0;
          end else if (!retry_out) begin
            retry_d = retry_q + RETRY_W'(1);
          end
        end
      end
      default: ;
    endcase
  end

  // Result entry for this transaction
  always_comb begin
    push       = 1'b0;
    ent.kind   = K_STORE;
    ent.offset = '0;
    ent.value  = '0;
    ent.count  = acc_q;
    ent.two    = 1'b0;
    ent.sum    = sum_add;
    case (op_e'(op_q))
      OP_START: begin
        if (total_q == '0) begin
          push      = 1'b1;
          ent.kind  = K_FINISH;
          ent.count = '0;
        end
      end
      OP_ERROR: begin
        if (phase_q != PH_IDLE) begin
          push     = 1'b1;
          ent.kind = K_ABORT;
        end
      end
      OP_BYTE: begin
        if (phase_q == PH_DATA) begin
          push       = 1'b1;
          ent.kind   = K_STORE;
          ent.offset = store_off;
          ent.value  = byte_q;
          ent.two    = blk_end;
        end else if (phase_q == PH_CHECK) begin
          push = 1'b1;
          if (sum_ok) begin
            ent.kind  = done ? K_FINISH : K_ACCEPT;
            ent.count = acc_add;
          end else if (retry_out) begin
            ent.kind  = K_FAIL;
            ent.count = '0;
          end else begin
            ent.kind = K_RETRY;
          end
        end
      end
      default: ;
    endcase
  end

  // State registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      pos_q   <= '0;
      sum_q   <= '0;
      retry_q <= '0;
      acc_q   <= '0;
    end else if (proceed) begin
      phase_q <= phase_d;
      pos_q   <= pos_d;
      sum_q   <= sum_d;
      retry_q <= retry_d;
      acc_q   <= acc_d;
    end
  end

  cbd_res_q u_res_q (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (proceed && push),
    .push_data_i  (ent),
    .push_ready_o (push_ready),
    .valid_o      (out_valid_o),
    .ready_i      (out_ready_i),
    .kind_o       (kind_o),
    .offset_o     (offset_o),
    .value_o      (value_o),
    .count_o      (count_o),
    .last_o       (last_o)
  );

  // Checks
  `CBD_ASSERT_IMP(a_pos_in_block, clk_i, rst_ni, phase_q == PH_DATA, pos_q < POS_W'(BLOCK_BYTES))
  `CBD_ASSERT_IMP(a_pos_at_check, clk_i, rst_ni, phase_q == PH_CHECK, pos_q == POS_W'(BLOCK_BYTES))
  `CBD_ASSERT_IMP(a_first_of_two, clk_i, rst_ni, out_valid_o && !last_o, kind_o == K_STORE)
  `CBD_ASSERT_NXT(a_sum_follows, clk_i, rst_ni, out_valid_o && out_ready_i && !last_o, out_valid_o && kind_o == K_SENDSUM)

endmodule
`default_nettype wire

// ===== sim/tb_top.sv =====
// Self-checking testbench for the checksummed block download receiver.
`timescale 1ns / 100ps
module tb_top;
  import cbd_pkg::*;

  localparam logic [OP_W-1:0] OP_SPARE = 2'd3;  // unused op code, ignored by the block
  localparam int unsigned ITEM_BUDGET  = 1850;
  localparam int unsigned DRAIN_CYCLES = 8;
  localparam int unsigned HOLD_AT      = 700;
  localparam int unsigned HOLD_CYCLES  = 300;
  localparam int unsigned QUIET_FROM   = 2000;
  localparam int unsigned QUIET_TO     = 3200;
  localparam int unsigned WATCHDOG_NS  = 400_000;

  typedef struct {
    logic [OP_W-1:0]   op;
    logic [BYTE_W-1:0] rx_byte;
  } link_item_t;

  typedef struct {
    kind_e              kind;
    logic [COUNT_W-1:0] offset;
    logic [BYTE_W-1:0]  value;
    logic [COUNT_W-1:0] count;
    logic               last;
  } dl_report_t;

  // DUT connections, all inputs known from time zero
  logic                 clk       = 1'b0;
  logic                 rst_n     = 1'b0;
  logic                 cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx   = '0;
  logic [CFG_W-1:0]     cfg_data  = '0;
  logic                 in_valid  = 1'b0;
  logic                 in_ready;
  logic [OP_W-1:0]      op        = '0;
  logic [BYTE_W-1:0]    rx_byte   = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [KIND_W-1:0]    kind;
  logic [COUNT_W-1:0]   offset;
  logic [BYTE_W-1:0]    value;
  logic [COUNT_W-1:0]   count;
  logic                 last;

  // Link traffic still to be offered, and reports the block still owes
  link_item_t  link_traffic[$];
  dl_report_t  due_reports[$];
  link_item_t  next_item;
  dl_report_t  head_report;
  int unsigned items_queued   = 0;
  int unsigned items_accepted = 0;
  int unsigned fault_cnt      = 0;

  // Receiver-side cycle count and long hold-off
  int unsigned rx_cycles = 0;
  int unsigned rx_hold   = 0;
  wire         quiet     = (rx_cycles >= QUIET_FROM) && (rx_cycles < QUIET_TO);

  // Shadow of the download state and registers
  phase_e             dl_phase        = PH_IDLE;
  logic [POS_W-1:0]   blk_pos         = '0;
  logic [BYTE_W-1:0]  blk_sum         = '0;
  logic [RETRY_W-1:0] retries         = '0;
  logic [COUNT_W-1:0] acc_bytes       = '0;
  logic [TOTAL_W-1:0] cfg_total       = '0;
  logic [RETRY_W-1:0] cfg_retry_limit = RETRY_LIMIT_RESET;

  checksummed_block_download u_top (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_data_i  (cfg_data),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .op_i        (op),
    .rx_byte_i   (rx_byte),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .kind_o      (kind),
    .offset_o    (offset),
    .value_o     (value),
    .count_o     (count),
    .last_o      (last)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic void owe_report(kind_e k, logic [COUNT_W-1:0] off,
                                     logic [BYTE_W-1:0] val, logic [COUNT_W-1:0] cnt,
                                     logic lst);
    dl_report_t r;
    r.kind   = k;
    r.offset = off;
    r.value  = val;
    r.count  = cnt;
    r.last   = lst;
    due_reports.push_back(r);
  endfunction

  // Advance the shadow state by one accepted link item
  function automatic void advance_download(logic [OP_W-1:0] code, logic [BYTE_W-1:0] b);
    logic [COUNT_W-1:0] off;
    case (code)
      OP_START: begin
        blk_pos   = '0;
        blk_sum   = '0;
        retries   = '0;
        acc_bytes = '0;
        if (cfg_total == '0) begin
          dl_phase = PH_IDLE;
          owe_report(K_FINISH, '0, '0, '0, 1'b1);
        end else begin
          dl_phase = PH_DATA;
        end
      end
      OP_ERROR: begin
        if (dl_phase != PH_IDLE) begin
          dl_phase = PH_IDLE;
          owe_report(K_ABORT, '0, '0, acc_bytes, 1'b1);
        end
      end
      OP_BYTE: begin
        if (dl_phase == PH_DATA) begin
          off     = acc_bytes + COUNT_W'(blk_pos);
          blk_sum = blk_sum + b;
          blk_pos = blk_pos + POS_W'(1);
          if (blk_pos >= POS_W'(BLOCK_BYTES)) begin
            dl_phase = PH_CHECK;
            owe_report(K_STORE, off, b, acc_bytes, 1'b0);
            owe_report(K_SENDSUM, '0, blk_sum, acc_bytes, 1'b1);
          end else begin
            owe_report(K_STORE, off, b, acc_bytes, 1'b1);
          end
        end else if (dl_phase == PH_CHECK) begin
          if (b == blk_sum) begin
            acc_bytes = acc_bytes + COUNT_W'(BLOCK_BYTES);
            retries   = '0;
            if (acc_bytes >= COUNT_W'(cfg_total)) begin
              dl_phase = PH_IDLE;
              owe_report(K_FINISH, '0, '0, acc_bytes, 1'b1);
            end else begin
              dl_phase = PH_DATA;
              owe_report(K_ACCEPT, '0, '0, acc_bytes, 1'b1);
            end
          end else if (retries >= cfg_retry_limit) begin
            dl_phase = PH_IDLE;
            owe_report(K_FAIL, '0, '0, '0, 1'b1);
          end else begin
            retries  = retries + RETRY_W'(1);
            dl_phase = PH_DATA;
            owe_report(K_RETRY, '0, '0, acc_bytes, 1'b1);
          end
          blk_pos = '0;
          blk_sum = '0;
        end
      end
      default: ;
    endcase
  endfunction

  // Link driver: holds each transaction until accepted, idles at random
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        advance_download(op, rx_byte);
        items_accepted++;
      end
      if (!in_valid || in_ready) begin
        if (link_traffic.size() != 0 && (quiet || $urandom_range(99) >= 26)) begin
          next_item = link_traffic.pop_front();
          in_valid <= 1'b1;
          op       <= next_item.op;
          rx_byte  <= next_item.rx_byte;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Report sink: random stalls plus one long hold-off
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      rx_cycles <= rx_cycles + 1;
      if (rx_cycles == HOLD_AT) rx_hold <= HOLD_CYCLES;
      else if (rx_hold != 0) rx_hold <= rx_hold - 1;
      out_ready <= (rx_hold == 0) && (rx_cycles != HOLD_AT) &&
                   (quiet || $urandom_range(99) >= 26);
    end
  end

  // Compare each report transaction with the oldest one owed
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (due_reports.size() == 0) begin
        if (fault_cnt < 10)
          $display("%0t: unexpected report kind %0d offset %0d value %0d count %0d last %0b",
                   $time, kind, offset, value, count, last);
        fault_cnt++;
      end else begin
        head_report = due_reports.pop_front();
        if (kind !== head_report.kind || offset !== head_report.offset ||
            value !== head_report.value || count !== head_report.count ||
            last !== head_report.last) begin
          if (fault_cnt < 10)
            $display("%0t: report mismatch (exp/got) kind %0d/%0d offset %0d/%0d value %0d/%0d",
                     $time, head_report.kind, kind, head_report.offset, offset,
                     head_report.value, value);
          if (fault_cnt < 10)
            $display("    count %0d/%0d last %0b/%0b",
                     head_report.count, count, head_report.last, last);
          fault_cnt++;
        end
      end
    end
  end

  task automatic send(input logic [OP_W-1:0] code, input logic [BYTE_W-1:0] b);
    link_item_t it;
    it.op      = code;
    it.rx_byte = b;
    link_traffic.push_back(it);
    items_queued++;
  endtask

  // Wait until every item is taken and every report has arrived
  task automatic settle();
    do @(posedge clk);
    while (items_accepted != items_queued || due_reports.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic configure(input logic [TOTAL_W-1:0] total, input logic [RETRY_W-1:0] limit);
    cfg_we   <= 1'b1;
    cfg_idx  <= CFG_TOTAL_BYTES;
    cfg_data <= CFG_W'(total);
    @(posedge clk);
    cfg_idx  <= CFG_RETRY_LIMIT;
    cfg_data <= CFG_W'(limit);
    @(posedge clk);
    cfg_we <= 1'b0;
    cfg_total       = total;
    cfg_retry_limit = limit;
  endtask

  // One well-formed transfer with random content and occasional noise
  task automatic run_transfer(input logic [TOTAL_W-1:0] total, input logic [RETRY_W-1:0] limit);
    int unsigned done_bytes;
    int unsigned tries;
    int unsigned compares;
    int unsigned pos;
    int unsigned noise;
    int unsigned pattern;
    logic [BYTE_W-1:0] sum;
    logic [BYTE_W-1:0] b;
    bit running;
    send(OP_START, 8'($urandom_range(255)));
    done_bytes = 0;
    tries      = 0;
    compares   = 0;
    running    = (total != '0);
    while (running) begin
      sum     = '0;
      pos     = 0;
      pattern = $urandom_range(7);
      while (running && pos < BLOCK_BYTES) begin
        noise = $urandom_range(1999);
        if (noise == 0 || items_queued >= ITEM_BUDGET) begin
          // link error, also used to close the run at the item budget
          send(OP_ERROR, 8'($urandom_range(255)));
          running = 1'b0;
        end else if (noise == 1) begin
          // restart mid-transfer
          send(OP_START, 8'($urandom_range(255)));
          done_bytes = 0;
          tries      = 0;
          sum        = '0;
          pos        = 0;
        end else begin
          if (noise < 6) send(OP_SPARE, 8'($urandom_range(255)));
          b = (pattern == 0) ? 8'hFF : (pattern == 1) ? 8'h00 : 8'($urandom_range(255));
          send(OP_BYTE, b);
          sum = sum + b;
          pos++;
        end
      end
      if (running && $urandom_range(19) == 0) begin
        // abort while the partner checksum is awaited
        send(OP_ERROR, 8'($urandom_range(255)));
        running = 1'b0;
      end
      if (running) begin
        if ($urandom_range(9) < 6) begin
          send(OP_BYTE, sum);
          done_bytes += BLOCK_BYTES;
          tries = 0;
          if (done_bytes >= total) running = 1'b0;
        end else begin
          send(OP_BYTE, sum ^ 8'($urandom_range(255, 1)));
          if (tries >= limit) running = 1'b0;
          else tries++;
        end
        compares++;
        if (running && compares >= 4) begin
          send(OP_ERROR, 8'($urandom_range(255)));
          running = 1'b0;
        end
      end
    end
  endtask

  // Stimulus and end of run
  initial begin
    logic [TOTAL_W-1:0] total;
    logic [RETRY_W-1:0] limit;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    settle();

    // Reset settings: idle items ignored, empty transfer finishes at once
    send(OP_BYTE, 8'hFF);
    send(OP_ERROR, 8'h00);
    send(OP_SPARE, 8'hAA);
    send(OP_START, 8'h55);
    settle();

    // Largest total and retry limit: stores, ignored spare op, restart, abort
    configure(24'hFFFFFF, 4'd15);
    send(OP_START, 8'h00);
    send(OP_BYTE, 8'h00);
    send(OP_BYTE, 8'hFF);
    send(OP_SPARE, 8'h00);
    send(OP_BYTE, 8'h5A);
    send(OP_START, 8'hFF);
    send(OP_BYTE, 8'h80);
    send(OP_BYTE, 8'h01);
    send(OP_ERROR, 8'hFF);
    send(OP_ERROR, 8'h00);
    send(OP_BYTE, 8'h7E);
    settle();

    // Smallest nonzero total and zero retries: double start, abort
    configure(24'd1, 4'd0);
    send(OP_START, 8'h00);
    send(OP_BYTE, 8'h7F);
    send(OP_START, 8'h00);
    send(OP_BYTE, 8'hC3);
    send(OP_ERROR, 8'h3C);
    settle();

    // Random transfers under varied settings
    while (items_queued < ITEM_BUDGET) begin
      case ($urandom_range(5))
        0: total = 24'($urandom_range(512, 1));
        1: total = 24'($urandom_range(1024, 513));
        2: total = 24'($urandom_range(1536, 1025));
        3: total = 24'(BLOCK_BYTES);
        4: total = 24'hFFFFFF;
        default: total = '0;
      endcase
      case ($urandom_range(3))
        0: limit = 4'd0;
        1: limit = 4'd1;
        2: limit = 4'd15;
        default: limit = 4'($urandom_range(15));
      endcase
      configure(total, limit);
      run_transfer(total, limit);
      settle();
    end

    if (fault_cnt == 0 && due_reports.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #(WATCHDOG_NS);
    $display("FAILURE");
    $finish;
  end

endmodule
